>>> rtl/wbps_pkg.sv
`default_nettype none

package wbps_pkg;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_REJECTED  = 2'd2
  } status_t;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_MASK  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS   = 3'd4;

  // bytes of pattern that the pattern registers can hold
  localparam int REG_PATTERN_BYTES = 16;
  localparam int LEN_W             = 5;

  localparam logic [63:0] REGION_LIMIT    = 64'h0000_0000_1000_0000;
  localparam logic [63:0] KERNEL_BOUNDARY = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/wbps_cell.sv
`default_nettype none

module wbps_cell #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int CELL_IDX          = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire wbps_pkg::cell_ctl_t        ctl,
  input  wire logic [7:0]                 byte_in,
  input  wire logic [wbps_pkg::LEN_W-1:0] len,
  input  wire logic [7:0]                 pattern [MAX_PATTERN_BYTES],
  input  wire logic [MAX_PATTERN_BYTES-1:0] wild,
  output logic      [7:0]                 byte_out,
  output logic                            hit
);
  import wbps_pkg::*;

  localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  logic [LEN_W:0] len_ext;
  logic [LEN_W:0] pos;
  logic           in_use;
  logic           pos_ok;
  logic [7:0]     sel_byte;
  logic           sel_wild;

  // this cell's byte lines up with pattern byte len-1-CELL_IDX
  always_comb begin
    len_ext  = {1'b0, len};
    pos      = len_ext - (LEN_W+1)'(CELL_IDX + 1);
    in_use   = len_ext > (LEN_W+1)'(CELL_IDX);
    pos_ok   = pos < (LEN_W+1)'(MAX_PATTERN_BYTES);
    sel_byte = pos_ok ? pattern[pos[IDX_W-1:0]] : 8'h00;
    sel_wild = pos_ok ? wild[pos[IDX_W-1:0]] : 1'b0;
    hit      = !in_use || sel_wild || (byte_in == sel_byte);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      byte_out <= 8'h00;
    end else if (ctl.shift) begin
      byte_out <= byte_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wildcard_byte_pattern_search_top.sv
`default_nettype none

// Wildcard byte pattern search. Region bytes stream in one per clock; each
// accepted byte shifts through a row of MAX_PATTERN_BYTES window cells that
// compare against the aligned pattern byte in parallel, so a byte is taken
// every unstalled cycle and its result (found, not found, or rejected) is
// loaded into the output register at the same edge and shows on the next
// cycle. The row compare and the 64-bit address add feed the output
// register. One result comes out per region; the input stalls only while a
// result is waiting and out_stall is high. last_byte ends the region and
// clears the window, the byte count and the result flag.
module wildcard_byte_pattern_search_top #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int COUNTER_BITS      = 29
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]                      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             last_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output wbps_pkg::status_t                     status,
  output logic [63:0]                           match_address
);
  import wbps_pkg::*;

  logic [63:0]      pattern_low;
  logic [63:0]      pattern_high;
  logic [15:0]      wildcard_mask;
  logic [LEN_W-1:0] pattern_length;
  logic [63:0]      base_address;

  logic [COUNTER_BITS-1:0] byte_counter;
  logic [COUNTER_BITS-1:0] byte_counter_next;
  logic                    result_given;

  logic [7:0]                   pattern [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] wild;
  logic [7:0]                   chain [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hit;
  cell_ctl_t                    ctl;

  logic        in_accept;
  logic        bad_setup;
  logic        too_long;
  logic        matched;
  logic        emit;
  status_t     res_status;
  logic [63:0] res_address;
  logic [63:0] count_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      wildcard_mask  <= '0;
      pattern_length <= '0;
      base_address   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_WILDCARD_MASK:  wildcard_mask  <= cfg_data[15:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_BASE_ADDRESS:   base_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pattern bytes past the register width are zero and never wild
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_pat
    if (i < 8) begin : g_lo
      assign pattern[i] = pattern_low[8*i +: 8];
      assign wild[i]    = wildcard_mask[i];
    end else if (i < REG_PATTERN_BYTES) begin : g_hi
      assign pattern[i] = pattern_high[8*(i-8) +: 8];
      assign wild[i]    = wildcard_mask[i];
    end else begin : g_zero
      assign pattern[i] = 8'h00;
      assign wild[i]    = 1'b0;
    end
  end

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign ctl.shift = in_accept;
  assign ctl.clear = in_accept && last_byte;
  assign chain[0]  = data_byte;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    if (k < MAX_PATTERN_BYTES - 1) begin : g_mid
      wbps_cell #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
        .CELL_IDX         (k)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .byte_in (chain[k]),
        .len     (pattern_length),
        .pattern (pattern),
        .wild    (wild),
        .byte_out(chain[k+1]),
        .hit     (hit[k])
      );
    end else begin : g_end
      // oldest byte falls off the end of the row
      wbps_cell #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
        .CELL_IDX         (k)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .byte_in (chain[k]),
        .len     (pattern_length),
        .pattern (pattern),
        .wild    (wild),
        .byte_out(),
        .hit     (hit[k])
      );
    end
  end

  always_comb begin
    byte_counter_next = (byte_counter == {COUNTER_BITS{1'b1}}) ? byte_counter
                                                               : byte_counter + 1'b1;
    count_ext   = 64'(byte_counter_next);
    bad_setup   = (pattern_length == '0) ||
                  ({1'b0, pattern_length} > (LEN_W+1)'(MAX_PATTERN_BYTES)) ||
                  (base_address <= KERNEL_BOUNDARY);
    too_long    = count_ext > REGION_LIMIT;
    matched     = (&hit) && (count_ext >= 64'(pattern_length));
    emit        = 1'b1;
    res_status  = ST_NOT_FOUND;
    res_address = '0;
    if (bad_setup || too_long) begin
      res_status = ST_REJECTED;
    end else if (matched) begin
      res_status  = ST_FOUND;
      res_address = base_address + (count_ext - 64'(pattern_length));
    end else if (!last_byte) begin
      emit = 1'b0;
    end
    if (result_given) begin
      emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter <= '0;
      result_given <= 1'b0;
    end else if (in_accept) begin
      if (last_byte) begin
        byte_counter <= '0;
        result_given <= 1'b0;
      end else begin
        byte_counter <= byte_counter_next;
        result_given <= result_given || emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // hold the result until its transfer
  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      status        <= res_status;
      match_address <= res_address;
    end
  end

  a_addr_zero_unless_found: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> (match_address == 64'd0)
  ) else $error("nonzero address on a result that is not found");

  a_region_end_clears: assert property (
    @(posedge clk) disable iff (rst)
    (in_accept && last_byte) |=> (byte_counter == '0 && !result_given)
  ) else $error("scan state not cleared after last byte");

  a_one_result_per_region: assert property (
    @(posedge clk) disable iff (rst)
    (in_accept && result_given && !last_byte) |=> result_given
  ) else $error("result flag dropped inside a region");

  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (rst)
    in_stall |-> out_valid
  ) else $error("input stalled with no result waiting");

endmodule

`default_nettype wire
